// ----- design/bsm_pkg.sv -----
// bounding sphere merge package: word types, carried item context and width constants
// no dependencies; used by bounding_sphere_merge_core and its checker
package bsm_pkg;

   // centre and radius width, Q12.12
   localparam int COORD_WIDTH = 24;
   localparam int RAD_WIDTH   = COORD_WIDTH + 1;
   localparam int SQ_WIDTH    = 2 * RAD_WIDTH;

   // pipeline step counts: one root bit and one quotient bit per stage
   localparam int SQRT_STEPS = RAD_WIDTH;
   localparam int DIV_STEPS  = COORD_WIDTH;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_x;
      logic signed [COORD_WIDTH-1:0] a_y;
      logic signed [COORD_WIDTH-1:0] a_z;
      logic [COORD_WIDTH-1:0]        a_radius;
      logic signed [COORD_WIDTH-1:0] b_x;
      logic signed [COORD_WIDTH-1:0] b_y;
      logic signed [COORD_WIDTH-1:0] b_z;
      logic [COORD_WIDTH-1:0]        b_radius;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] merged_x;
      logic signed [COORD_WIDTH-1:0] merged_y;
      logic signed [COORD_WIDTH-1:0] merged_z;
      logic [RAD_WIDTH-1:0]          merged_radius;
      logic [SQ_WIDTH-1:0]           growth;
      logic                          enclosed;
      logic                          overlaps;
   } rsp_type;

   // per-item values that ride along the whole pipeline
   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0]   a_c;
      logic [2:0][COORD_WIDTH-1:0]   b_c;
      logic [2:0][COORD_WIDTH-1:0]   mag;
      logic [2:0]                    neg;
      logic [COORD_WIDTH-1:0]        ra;
      logic [COORD_WIDTH-1:0]        rb;
      logic [2*COORD_WIDTH-1:0]      ra2;
      logic                          encl;
      logic                          ovl;
   } ctx_type;

endpackage

// ----- design/bounding_sphere_merge_core.sv -----
// Smallest sphere enclosing two spheres (Q12.12 centres and radii) with growth and overlap
// flags. Fully pipelined: one word accepted per cycle unless the result side stalls; the
// pipeline runs through the bit-per-stage square root (one stage per root bit), then the
// bit-per-stage divider (one stage per quotient bit, three lanes side by side). A stall
// on the result side freezes the whole pipeline.
// Depends on bsm_pkg.
module bounding_sphere_merge_core
   import bsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = COORD_WIDTH;
   localparam int RW = CW + 4;

   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // whole pipeline moves unless the output word is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stage 1: offsets, magnitudes, radius sum and difference
   logic s1_valid_ff;
   ctx_type s1_ctx_ff, s1_ctx_in;
   logic [CW-1:0] s1_rdiff_ff, s1_rdiff_in;
   logic [CW:0] s1_rs_ff, s1_rs_in;

   always_comb begin
      logic signed [CW:0] off;
      s1_ctx_in = '0;
      s1_ctx_in.a_c[0] = req_data.a_x;
      s1_ctx_in.a_c[1] = req_data.a_y;
      s1_ctx_in.a_c[2] = req_data.a_z;
      s1_ctx_in.b_c[0] = req_data.b_x;
      s1_ctx_in.b_c[1] = req_data.b_y;
      s1_ctx_in.b_c[2] = req_data.b_z;
      s1_ctx_in.ra = req_data.a_radius;
      s1_ctx_in.rb = req_data.b_radius;
      for (int i = 0; i < 3; i++) begin
         off = $signed({s1_ctx_in.b_c[i][CW-1], s1_ctx_in.b_c[i]})
             - $signed({s1_ctx_in.a_c[i][CW-1], s1_ctx_in.a_c[i]});
         s1_ctx_in.neg[i] = off[CW];
         s1_ctx_in.mag[i] = off[CW] ? CW'(-off) : off[CW-1:0];
      end
      s1_rdiff_in = (req_data.a_radius > req_data.b_radius)
                  ? req_data.a_radius - req_data.b_radius
                  : req_data.b_radius - req_data.a_radius;
      s1_rs_in = {1'b0, req_data.a_radius} + {1'b0, req_data.b_radius};
   end

   // stage 2: squares
   logic s2_valid_ff;
   ctx_type s2_ctx_ff, s2_ctx_in;
   logic [2:0][2*CW-1:0] s2_sq_ff, s2_sq_in;
   logic [2*CW-1:0] s2_rd2_ff, s2_rd2_in;
   logic [SQ_WIDTH-1:0] s2_rs2_ff, s2_rs2_in;

   always_comb begin
      s2_ctx_in = s1_ctx_ff;
      s2_ctx_in.ra2 = (2*CW)'(s1_ctx_ff.ra) * (2*CW)'(s1_ctx_ff.ra);
      for (int i = 0; i < 3; i++) begin
         s2_sq_in[i] = (2*CW)'(s1_ctx_ff.mag[i]) * (2*CW)'(s1_ctx_ff.mag[i]);
      end
      s2_rd2_in = (2*CW)'(s1_rdiff_ff) * (2*CW)'(s1_rdiff_ff);
      s2_rs2_in = SQ_WIDTH'(s1_rs_ff) * SQ_WIDTH'(s1_rs_ff);
   end

   // stage 3: squared distance
   logic s3_valid_ff;
   ctx_type s3_ctx_ff;
   logic [SQ_WIDTH-1:0] s3_dist2_ff, s3_dist2_in;
   logic [2*CW-1:0] s3_rd2_ff;
   logic [SQ_WIDTH-1:0] s3_rs2_ff;

   assign s3_dist2_in = SQ_WIDTH'(s2_sq_ff[0]) + SQ_WIDTH'(s2_sq_ff[1])
                      + SQ_WIDTH'(s2_sq_ff[2]);

   // stage 4: enclosure and overlap tests
   logic s4_valid_ff;
   ctx_type s4_ctx_ff, s4_ctx_in;
   logic [SQ_WIDTH-1:0] s4_dist2_ff;

   always_comb begin
      s4_ctx_in = s3_ctx_ff;
      s4_ctx_in.encl = SQ_WIDTH'(s3_rd2_ff) >= s3_dist2_ff;
      s4_ctx_in.ovl  = s3_rs2_ff > s3_dist2_ff;
   end

   // square root: one result bit per stage
   logic [SQRT_STEPS-1:0] sq_valid_ff;
   ctx_type sq_ctx_ff [SQRT_STEPS];
   logic [SQ_WIDTH-1:0] sq_n_ff [SQRT_STEPS];
   logic [SQ_WIDTH-1:0] sq_n_in [SQRT_STEPS];
   logic [RW-1:0] sq_rem_ff [SQRT_STEPS];
   logic [RW-1:0] sq_rem_in [SQRT_STEPS];
   logic [RAD_WIDTH-1:0] sq_root_ff [SQRT_STEPS];
   logic [RAD_WIDTH-1:0] sq_root_in [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [SQ_WIDTH-1:0]  n_src;
      logic [RW-1:0]        rem_src;
      logic [RAD_WIDTH-1:0] root_src;
      logic [RW-1:0]        trial;
      logic [RW-1:0]        test;

      if (k == 0) begin : g_first
         assign n_src    = s4_dist2_ff;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign n_src    = sq_n_ff[k-1];
         assign rem_src  = sq_rem_ff[k-1];
         assign root_src = sq_root_ff[k-1];
      end

      always_comb begin
         trial = {rem_src[RW-3:0], n_src[SQ_WIDTH-1 -: 2]};
         test  = RW'({root_src, 2'b01});
         sq_n_in[k] = {n_src[SQ_WIDTH-3:0], 2'b00};
         if (trial >= test) begin
            sq_rem_in[k]  = trial - test;
            sq_root_in[k] = {root_src[RAD_WIDTH-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = trial;
            sq_root_in[k] = {root_src[RAD_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ctx_ff[k]  <= (k == 0) ? s4_ctx_ff : sq_ctx_ff[(k == 0) ? 0 : k-1];
            sq_n_ff[k]    <= sq_n_in[k];
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
         end
      end
   end

   // new radius and centre factor
   logic n1_valid_ff;
   ctx_type n1_ctx_ff;
   logic [RAD_WIDTH-1:0] n1_d_ff, n1_newr_ff, n1_newr_in, n1_fac_ff, n1_fac_in;

   always_comb begin
      logic [RAD_WIDTH:0] total;
      logic [RAD_WIDTH-1:0] d;
      ctx_type c;
      c = sq_ctx_ff[SQRT_STEPS-1];
      d = sq_root_ff[SQRT_STEPS-1];
      total = (RAD_WIDTH+1)'(d) + (RAD_WIDTH+1)'(c.ra) + (RAD_WIDTH+1)'(c.rb);
      if (c.encl) begin
         n1_newr_in = RAD_WIDTH'((c.ra > c.rb) ? c.ra : c.rb);
      end else begin
         n1_newr_in = total[RAD_WIDTH:1];
      end
      n1_fac_in = n1_newr_in - RAD_WIDTH'(c.ra);
   end

   // offset products and squared new radius
   logic n2_valid_ff;
   ctx_type n2_ctx_ff;
   logic [RAD_WIDTH-1:0] n2_d_ff, n2_newr_ff;
   logic [2:0][2*CW:0] n2_prod_ff, n2_prod_in;
   logic [SQ_WIDTH-1:0] n2_nr2_ff, n2_nr2_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n2_prod_in[i] = (2*CW+1)'(n1_ctx_ff.mag[i]) * (2*CW+1)'(n1_fac_ff);
      end
      n2_nr2_in = SQ_WIDTH'(n1_newr_ff) * SQ_WIDTH'(n1_newr_ff);
   end

   // divider: one quotient bit per stage on each axis
   logic [DIV_STEPS-1:0] dv_valid_ff;
   ctx_type dv_ctx_ff [DIV_STEPS];
   logic [RAD_WIDTH-1:0] dv_d_ff [DIV_STEPS];
   logic [RAD_WIDTH-1:0] dv_newr_ff [DIV_STEPS];
   logic [SQ_WIDTH-1:0] dv_growth_ff [DIV_STEPS];
   logic [2:0][CW+1:0] dv_rem_ff [DIV_STEPS];
   logic [2:0][CW+1:0] dv_rem_in [DIV_STEPS];
   logic [2:0][CW-1:0] dv_low_ff [DIV_STEPS];
   logic [2:0][CW-1:0] dv_low_in [DIV_STEPS];
   logic [2:0][CW-1:0] dv_q_ff [DIV_STEPS];
   logic [2:0][CW-1:0] dv_q_in [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      ctx_type              ctx_src;
      logic [RAD_WIDTH-1:0] d_src;
      logic [RAD_WIDTH-1:0] newr_src;
      logic [SQ_WIDTH-1:0]  growth_src;
      logic [2:0][CW+1:0]   rem_src;
      logic [2:0][CW-1:0]   low_src;
      logic [2:0][CW-1:0]   q_src;

      if (k == 0) begin : g_first
         assign ctx_src    = n2_ctx_ff;
         assign d_src      = n2_d_ff;
         assign newr_src   = n2_newr_ff;
         assign growth_src = n2_nr2_ff - SQ_WIDTH'(n2_ctx_ff.ra2);
         for (genvar i = 0; i < 3; i++) begin : g_init
            assign rem_src[i] = {1'b0, n2_prod_ff[i][2*CW:CW]};
            assign low_src[i] = n2_prod_ff[i][CW-1:0];
         end
         assign q_src = '0;
      end else begin : g_next
         assign ctx_src    = dv_ctx_ff[k-1];
         assign d_src      = dv_d_ff[k-1];
         assign newr_src   = dv_newr_ff[k-1];
         assign growth_src = dv_growth_ff[k-1];
         assign rem_src    = dv_rem_ff[k-1];
         assign low_src    = dv_low_ff[k-1];
         assign q_src      = dv_q_ff[k-1];
      end

      always_comb begin
         logic [CW+1:0] trial;
         for (int i = 0; i < 3; i++) begin
            trial = {rem_src[i][CW:0], low_src[i][CW-1]};
            dv_low_in[k][i] = {low_src[i][CW-2:0], 1'b0};
            if (trial >= {1'b0, d_src}) begin
               dv_rem_in[k][i] = trial - {1'b0, d_src};
               dv_q_in[k][i]   = {q_src[i][CW-2:0], 1'b1};
            end else begin
               dv_rem_in[k][i] = trial;
               dv_q_in[k][i]   = {q_src[i][CW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ctx_ff[k]    <= ctx_src;
            dv_d_ff[k]      <= d_src;
            dv_newr_ff[k]   <= newr_src;
            dv_growth_ff[k] <= growth_src;
            dv_rem_ff[k]    <= dv_rem_in[k];
            dv_low_ff[k]    <= dv_low_in[k];
            dv_q_ff[k]      <= dv_q_in[k];
         end
      end
   end

   // output word: centre selection and result assembly
   always_comb begin
      ctx_type c;
      logic [2:0][CW-1:0] centre;
      c = dv_ctx_ff[DIV_STEPS-1];
      for (int i = 0; i < 3; i++) begin
         if (c.encl) begin
            centre[i] = (c.ra > c.rb) ? c.a_c[i] : c.b_c[i];
         end else if (c.neg[i]) begin
            centre[i] = c.a_c[i] - dv_q_ff[DIV_STEPS-1][i];
         end else begin
            centre[i] = c.a_c[i] + dv_q_ff[DIV_STEPS-1][i];
         end
      end
      rsp_data_in.merged_x      = centre[0];
      rsp_data_in.merged_y      = centre[1];
      rsp_data_in.merged_z      = centre[2];
      rsp_data_in.merged_radius = dv_newr_ff[DIV_STEPS-1];
      rsp_data_in.growth        = dv_growth_ff[DIV_STEPS-1];
      rsp_data_in.enclosed      = c.encl;
      rsp_data_in.overlaps      = c.ovl;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         sq_valid_ff  <= '0;
         n1_valid_ff  <= 1'b0;
         n2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         sq_valid_ff  <= {sq_valid_ff[SQRT_STEPS-2:0], s4_valid_ff};
         n1_valid_ff  <= sq_valid_ff[SQRT_STEPS-1];
         n2_valid_ff  <= n1_valid_ff;
         dv_valid_ff  <= {dv_valid_ff[DIV_STEPS-2:0], n2_valid_ff};
         rsp_valid_ff <= dv_valid_ff[DIV_STEPS-1];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctx_ff   <= s1_ctx_in;
         s1_rdiff_ff <= s1_rdiff_in;
         s1_rs_ff    <= s1_rs_in;
         s2_ctx_ff   <= s2_ctx_in;
         s2_sq_ff    <= s2_sq_in;
         s2_rd2_ff   <= s2_rd2_in;
         s2_rs2_ff   <= s2_rs2_in;
         s3_ctx_ff   <= s2_ctx_ff;
         s3_dist2_ff <= s3_dist2_in;
         s3_rd2_ff   <= s2_rd2_ff;
         s3_rs2_ff   <= s2_rs2_ff;
         s4_ctx_ff   <= s4_ctx_in;
         s4_dist2_ff <= s3_dist2_ff;
         n1_ctx_ff   <= sq_ctx_ff[SQRT_STEPS-1];
         n1_d_ff     <= sq_root_ff[SQRT_STEPS-1];
         n1_newr_ff  <= n1_newr_in;
         n1_fac_ff   <= n1_fac_in;
         n2_ctx_ff   <= n1_ctx_ff;
         n2_d_ff     <= n1_d_ff;
         n2_newr_ff  <= n1_newr_ff;
         n2_prod_ff  <= n2_prod_in;
         n2_nr2_ff   <= n2_nr2_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- design/bsm_checker.sv -----
// port-level checks for bounding_sphere_merge_core, attached by bind
// depends on bsm_pkg
module bsm_checker
   import bsm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held result word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result word changed");

   // input only stalls behind a held result word
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled without a held result");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word after reset");

   // an enclosed result radius fits the input radius width (top bit clear)
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.enclosed |-> rsp_data.merged_radius[RAD_WIDTH-1] == 1'b0)
      else $error("enclosed radius out of range");

endmodule

bind bounding_sphere_merge_core bsm_checker u_bsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
